/* rtl/hnpl_pkg.sv */
// ----------------------------------------------------------------------------
// hnpl_pkg: shared types and constants for the held note priority list
// Event codes, field widths and the request/result records passed between
// the stream wrapper and the list sequencer.
// ----------------------------------------------------------------------------
package hnpl_pkg;

    localparam int NOTE_W       = 7;
    localparam int VEL_W        = 7;
    localparam int OP_W         = 2;
    localparam int HCOUNT_W     = 2;
    localparam int DEFAULT_LIST_DEPTH = 3;

    // event kinds
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;

    typedef logic [NOTE_W-1:0] t_note;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        t_note            note;
        logic [VEL_W-1:0] velocity;
    } t_req;

    typedef struct packed {
        t_note               top_note;
        logic [HCOUNT_W-1:0] held_count;
        logic                changed;
        logic                dropped;
    } t_res;

endpackage

/* rtl/hnpl_core.sv */
// ----------------------------------------------------------------------------
// hnpl_core: slot list with one shared compare unit and a small sequencer
// Walks the list one slot per cycle to find a match or an insert point,
// then moves one slot per cycle to open or close the gap.
// ----------------------------------------------------------------------------
module hnpl_core #(
    parameter int LIST_DEPTH = hnpl_pkg::DEFAULT_LIST_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  hnpl_pkg::t_req i_req,
    output logic          o_idle,
    output logic          o_res_valid,
    output hnpl_pkg::t_res o_res,
    input  logic          i_res_take
);
    import hnpl_pkg::*;

    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(LIST_DEPTH - 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN_RM  = 3'd1;
    localparam logic [2:0] ST_SHIFT_UP = 3'd2;
    localparam logic [2:0] ST_SCAN_IN  = 3'd3;
    localparam logic [2:0] ST_SHIFT_DN = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    t_note          r_held [LIST_DEPTH];
    logic [CW-1:0]  r_count, n_count;
    logic [2:0]     r_state, n_state;
    logic [IW-1:0]  r_ptr, n_ptr;
    logic [IW-1:0]  r_pos, n_pos;
    logic [CW-1:0]  r_new_cnt, n_new_cnt;
    t_note          r_note, n_note;
    logic           r_changed, n_changed;
    logic           r_dropped, n_dropped;

    logic           wr_en;
    logic [IW-1:0]  wr_idx;
    t_note          wr_data;
    logic [IW-1:0]  rd_idx;
    t_note          rd_data;
    logic [CW-1:0]  ptr_ext, ptr_inc;
    logic           is_off, is_on;
    logic           cmp_eq, cmp_ge;

    assign ptr_ext = CW'(r_ptr);
    assign ptr_inc = ptr_ext + CW'(1);

    // single read port into the slot list
    always_comb begin
        case (r_state)
            ST_SHIFT_UP: rd_idx = ptr_inc[IW-1:0];
            ST_SHIFT_DN: rd_idx = r_ptr - IW'(1);
            default:     rd_idx = r_ptr;
        endcase
    end
    assign rd_data = r_held[rd_idx];

    // shared compare unit
    assign cmp_eq = (rd_data == r_note);
    assign cmp_ge = (r_note >= rd_data);

    assign is_off = (i_req.op == OP_NOTE_OFF) ||
                    ((i_req.op == OP_NOTE_ON) && (i_req.velocity == '0));
    assign is_on  = (i_req.op == OP_NOTE_ON) && (i_req.velocity != '0);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_pos     = r_pos;
        n_new_cnt = r_new_cnt;
        n_note    = r_note;
        n_changed = r_changed;
        n_dropped = r_dropped;
        wr_en     = 1'b0;
        wr_idx    = r_ptr;
        wr_data   = rd_data;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_note    = i_req.note;
                    n_changed = 1'b0;
                    n_dropped = 1'b0;
                    n_ptr     = '0;
                    if (i_req.note == '0) begin
                        n_state = ST_DONE;
                    end else if (is_off) begin
                        n_state = (r_count == '0) ? ST_DONE : ST_SCAN_RM;
                    end else if (is_on) begin
                        n_state = ST_SCAN_IN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN_RM: begin
                if (cmp_eq) begin
                    n_changed = 1'b1;
                    n_state   = ST_SHIFT_UP;
                end else if (ptr_inc >= r_count) begin
                    n_state = ST_DONE;
                end else begin
                    n_ptr = ptr_inc[IW-1:0];
                end
            end
            ST_SHIFT_UP: begin
                wr_en = 1'b1;
                if (ptr_inc < r_count) begin
                    wr_data = rd_data;
                    n_ptr   = ptr_inc[IW-1:0];
                end else begin
                    wr_data = '0;
                    n_count = r_count - CW'(1);
                    n_state = ST_DONE;
                end
            end
            ST_SCAN_IN: begin
                if ((ptr_ext >= r_count) || cmp_ge) begin
                    n_changed = 1'b1;
                    n_pos     = r_ptr;
                    if (r_count >= FULL_CNT) begin
                        // lowest note falls off the end
                        n_ptr     = LAST_IDX;
                        n_new_cnt = FULL_CNT;
                    end else begin
                        n_ptr     = r_count[IW-1:0];
                        n_new_cnt = r_count + CW'(1);
                    end
                    n_state = ST_SHIFT_DN;
                end else if (r_ptr == LAST_IDX) begin
                    n_dropped = 1'b1;
                    n_state   = ST_DONE;
                end else begin
                    n_ptr = ptr_inc[IW-1:0];
                end
            end
            ST_SHIFT_DN: begin
                wr_en = 1'b1;
                if (r_ptr > r_pos) begin
                    wr_data = rd_data;
                    n_ptr   = r_ptr - IW'(1);
                end else begin
                    wr_data = r_note;
                    n_count = r_new_cnt;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_pos     <= '0;
            r_new_cnt <= '0;
            r_changed <= 1'b0;
            r_dropped <= 1'b0;
            for (int k = 0; k < LIST_DEPTH; k++) begin
                r_held[k] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_pos     <= n_pos;
            r_new_cnt <= n_new_cnt;
            r_changed <= n_changed;
            r_dropped <= n_dropped;
            if (wr_en) begin
                r_held[wr_idx] <= wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_note <= n_note;
    end

    assign o_idle            = (r_state == ST_IDLE);
    assign o_res_valid       = (r_state == ST_DONE);
    assign o_res.top_note    = (r_count != '0) ? r_held[0] : '0;
    assign o_res.held_count  = r_count[HCOUNT_W-1:0];
    assign o_res.changed     = r_changed;
    assign o_res.dropped     = r_dropped;

endmodule

/* rtl/held_note_priority_list.sv */
// ----------------------------------------------------------------------------
// held_note_priority_list: highest-note priority list of held MIDI notes
// Stream wrapper around the list sequencer, with a registered result stage.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tuser = op; tdata = note, velocity
//  m_axis    out  tdata = top_note, held_count, changed, dropped
//
// A result is registered in the output stage once the sequencer finishes,
// and the next request is accepted once the sequencer returns to idle:
// the sequencer reads one slot per cycle through a single compare unit,
// first scanning for a match or insert point, then moving one slot per cycle.
// Reset is synchronous, active low, and empties the list.
// s_axis_tready is high only while the sequencer is idle; a result waiting
// in the output register does not block the next request, but a second
// finished result waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module held_note_priority_list #(
    parameter int LIST_DEPTH = hnpl_pkg::DEFAULT_LIST_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [6:0] note, [13:7] velocity, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [6:0] top_note, [8:7] held_count,
                                        // [9] changed, [10] dropped, rest zero
);
    import hnpl_pkg::*;

    t_req   req;
    t_res   core_res;
    t_res   r_out;
    logic   r_out_valid;
    logic   core_idle;
    logic   core_res_valid;
    logic   take;
    logic   start;

    assign req.op       = s_axis_tuser;
    assign req.note     = s_axis_tdata[NOTE_W-1:0];
    assign req.velocity = s_axis_tdata[NOTE_W+VEL_W-1:NOTE_W];

    assign s_axis_tready = core_idle;
    assign start         = s_axis_tvalid && core_idle;

    // output register loads a finished result whenever it is empty or being drained
    assign take = core_res_valid && (!r_out_valid || m_axis_tready);

    hnpl_core #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .o_idle      (core_idle),
        .o_res_valid (core_res_valid),
        .o_res       (core_res),
        .i_res_take  (take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.dropped, r_out.changed,
                            r_out.held_count, r_out.top_note};

endmodule

/* test/tb_held_note_priority_list.sv */
// ----------------------------------------------------------------------------
// tb_held_note_priority_list: self-checking bench for the held note list
// Drives note on / note off / ignored events into the request stream and
// checks every result against a cycle-free model of the sorted note list or a known result.
// A short directed table walks the corner cases from reset, then a long
// random run with idle bursts on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_held_note_priority_list;

    import hnpl_pkg::*;

    localparam int LIST_DEPTH   = DEFAULT_LIST_DEPTH;
    localparam int RANDOM_ITEMS = 1750;   // events in the random run
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
    localparam int LONG_HOLD    = 80;     // cycles the sink holds off once

    // ignored event kinds
    localparam logic [OP_W-1:0] OP_OTHER = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [6:0] note, [13:7] velocity, rest zero
    logic [1:0]  s_axis_tuser;   // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [6:0] top_note, [8:7] held_count,
                                 // [9] changed, [10] dropped, rest zero

    held_note_priority_list #(
        .LIST_DEPTH (LIST_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow note list: sorted high to low, slots past the count held at zero
    // ------------------------------------------------------------------------
    t_note held_list [LIST_DEPTH];
    int    held_n;

    t_res  pending_res [$];   // results owed by the block, oldest first
    int    fail_count;

    bit    quiet;             // end of run: no idle bursts on either side
    bit    hold_req;          // ask the sink for one long stall

    // Applies one event to the shadow list and returns the result it yields.
    function automatic t_res apply_event(input logic [OP_W-1:0] op, input t_note note,
                                         input logic [VEL_W-1:0] vel);
        t_res res;
        logic changed;
        logic dropped;
        logic done;
        int   pos;
        changed = 1'b0;
        dropped = 1'b0;
        done    = 1'b0;
        if (op == OP_NOTE_OFF || (op == OP_NOTE_ON && vel == '0)) begin
            // note off: first match goes, lower notes close the gap
            if (note != '0) begin
                for (int i = 0; i < LIST_DEPTH; i++) begin
                    if (!done && i < held_n && held_list[i] == note) begin
                        for (int j = i; j < held_n - 1; j++)
                            held_list[j] = held_list[j + 1];
                        held_list[held_n - 1] = '0;
                        held_n  = held_n - 1;
                        changed = 1'b1;
                        done    = 1'b1;
                    end
                end
            end
        end else if (op == OP_NOTE_ON && note != '0) begin
            // insert point: first free slot or first held note not above it,
            // so an equal note lands just above its twin
            pos = LIST_DEPTH;
            for (int i = LIST_DEPTH - 1; i >= 0; i--)
                if (i >= held_n || note >= held_list[i])
                    pos = i;
            if (pos == LIST_DEPTH) begin
                dropped = 1'b1;   // full, every held note higher
            end else begin
                if (held_n == LIST_DEPTH) begin
                    // steal the lowest note
                    held_list[LIST_DEPTH - 1] = '0;
                    held_n = LIST_DEPTH - 1;
                end
                for (int d = held_n; d > pos; d--)
                    held_list[d] = held_list[d - 1];
                held_list[pos] = note;
                held_n  = held_n + 1;
                changed = 1'b1;
            end
        end
        res.top_note   = (held_n > 0) ? held_list[0] : '0;
        res.held_count = held_n[HCOUNT_W-1:0];
        res.changed    = changed;
        res.dropped    = dropped;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Offers one request, waits for the handshake, then logs what it owes.
    // A known result (typed into the table) stands in for the model's.
    task automatic send_event(input logic [OP_W-1:0] op, input t_note note,
                              input logic [VEL_W-1:0] vel,
                              input logic use_known, input t_res known);
        t_res pred;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, vel, note};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = apply_event(op, note, vel);
        pending_res.push_back(use_known ? known : pred);
        // idle burst; between requests tvalid is only dropped here, never dropped and raised
        // in the same step
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Directed table
    typedef struct {
        logic [OP_W-1:0]  op;
        t_note            note;
        logic [VEL_W-1:0] vel;
        logic             known;
        t_res             res;
    } t_row;

    t_row directed_rows [$];

    task automatic row(input logic [OP_W-1:0] op, input int note, input int vel);
        t_row r;
        r.op    = op;
        r.note  = note[NOTE_W-1:0];
        r.vel   = vel[VEL_W-1:0];
        r.known = 1'b0;
        r.res   = '0;
        directed_rows.push_back(r);
    endtask

    task automatic row_known(input logic [OP_W-1:0] op, input int note, input int vel,
                             input int top, input int cnt, input bit chg, input bit drp);
        t_row r;
        r.op             = op;
        r.note           = note[NOTE_W-1:0];
        r.vel            = vel[VEL_W-1:0];
        r.known          = 1'b1;
        r.res.top_note   = top[NOTE_W-1:0];
        r.res.held_count = cnt[HCOUNT_W-1:0];
        r.res.changed    = chg;
        r.res.dropped    = drp;
        directed_rows.push_back(r);
    endtask

    initial begin : stimulus
        int            live_items;
        int            pick;
        logic [OP_W-1:0] op;
        t_note         note;
        logic [VEL_W-1:0] vel;
        t_row          r;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_OTHER;
        i_rst_n       <= 1'b0;
        held_n     = 0;
        fail_count = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        live_items = 0;
        for (int i = 0; i < LIST_DEPTH; i++)
            held_list[i] = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: ignored kinds, note 0, misses
        row_known(OP_OTHER,    127, 127,   0, 0, 0, 0);
        row_known(OP_RSVD,       0,   0,   0, 0, 0, 0);
        row_known(OP_NOTE_OFF,   0,   0,   0, 0, 0, 0);   // note off of 0
        row_known(OP_NOTE_ON,    0, 127,   0, 0, 0, 0);   // note on of 0 ignored
        row_known(OP_NOTE_ON,   60,   0,   0, 0, 0, 0);   // vel 0 = off, no match
        row_known(OP_NOTE_OFF,  60, 127,   0, 0, 0, 0);
        row_known(OP_NOTE_ON,  127, 127, 127, 1, 1, 0);
        // fill up, equal notes, steal, drop
        row(OP_NOTE_ON,    1,   1);
        row(OP_NOTE_ON,   64,  85);
        row(OP_NOTE_ON,    1,  42);   // equal to lowest of a full list
        row(OP_NOTE_ON,   64, 127);   // twin goes above existing copy
        row_known(OP_NOTE_ON,   10, 100, 127, 3, 0, 1);   // below all: dropped
        row(OP_NOTE_ON,  127, 127);
        row(OP_OTHER,    127,  85);
        // removals
        row(OP_NOTE_OFF, 127,  42);
        row(OP_NOTE_ON,   64,   0);
        row(OP_NOTE_OFF,   0, 127);
        row(OP_NOTE_OFF,   5,   0);
        row(OP_NOTE_OFF, 127,   0);
        // refill, steal from the bottom, remove the lowest note
        row(OP_NOTE_ON,   85, 127);
        row(OP_NOTE_ON,   42,  85);
        row(OP_NOTE_ON,   21,  42);
        row(OP_NOTE_ON,  100,  21);
        row(OP_NOTE_OFF,  42,  85);
        row(OP_RSVD,      85,  42);

        foreach (directed_rows[k]) begin
            r = directed_rows[k];
            send_event(r.op, r.note, r.vel, r.known, r.res);
        end

        // random run: mostly note on/off over a narrow pool so notes collide,
        // with held notes picked back for any event kind
        while (live_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                op = $urandom_range(0, 1) ? OP_OTHER : OP_RSVD;
            else if (pick < 58)
                op = OP_NOTE_ON;
            else
                op = OP_NOTE_OFF;

            pick = $urandom_range(0, 99);
            if (pick < 35 && held_n > 0)
                note = held_list[$urandom_range(0, held_n - 1)];
            else if (pick < 70)
                note = NOTE_W'($urandom_range(60, 67));
            else
                note = NOTE_W'($urandom_range(0, 127));

            vel = ($urandom_range(0, 7) == 0) ? '0 : VEL_W'($urandom_range(0, 127));

            live_items++;
            if (live_items == 300)
                hold_req = 1'b1;   // fill the block while the sink stalls
            if (live_items > RANDOM_ITEMS - 150)
                quiet = 1'b1;
            send_event(op, note, vel, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_res.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, one long stall on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_cycles;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
                    @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare each accepted result with the oldest one owed
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_res.pop_front();
                report_field("top_note",   want.top_note,   m_axis_tdata[6:0]);
                report_field("held_count", want.held_count, m_axis_tdata[8:7]);
                report_field("changed",    want.changed,    m_axis_tdata[9]);
                report_field("dropped",    want.dropped,    m_axis_tdata[10]);
            end
        end
    end

    // Hard stop: far beyond the slowest legal run
    initial begin : watchdog
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
